### rtl/sob_pkg.sv
// Shared types, constants and helpers of the Sobel gradient filter.
`default_nettype none
package sob_pkg;
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int LANES_DEF     = 3;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_X_ORDER  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_ORDER  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BORDER   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONSTANT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN     = 3'd7;

   localparam logic [1:0] BORDER_CONST   = 2'd0;
   localparam logic [1:0] BORDER_REPL    = 2'd1;
   localparam logic [1:0] BORDER_REFLECT = 2'd2;

   localparam logic [1:0] ORD_SMOOTH = 2'd0;
   localparam logic [1:0] ORD_DERIV  = 2'd1;
   localparam logic [1:0] ORD_SECOND = 2'd2;
   localparam logic [1:0] ORD_SCHARR = 2'd3;

   // front sequencer states
   typedef enum logic [1:0] {F_READ, F_EMIT, F_LAST} fstate_type;

   // one window column set plus output tags, front to back
   typedef struct packed {
      logic [8:0][23:0] cols;
      logic [10:0]      column;
      logic [11:0]      row;
      logic             row_end;
      logic             frame_end;
   } job_type;

   typedef struct packed {
      logic [1:0]  x_order;
      logic [1:0]  y_order;
      logic [1:0]  nch;
      logic [15:0] gain;
   } math_cfg_type;

   // 3-tap kernel: a*k0 + b*k1 + c*k2, 16-bit wrapped
   function automatic logic [15:0] tap3(input logic [1:0] ord, input logic [15:0] a,
                                        input logic [15:0] b, input logic [15:0] c);
      logic [15:0] r;
      case (ord)
         ORD_SMOOTH: r = a + (b << 1) + c;
         ORD_DERIV:  r = c - a;
         ORD_SECOND: r = a - (b << 1) + c;
         ORD_SCHARR: r = (a << 1) + a + (b << 3) + (b << 1) + (c << 1) + c;
         default:    r = '0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

### rtl/sobel_3x3_gradient_filter_core.sv
// Top level of the streaming 3x3 Sobel/Scharr gradient filter.
//  channel | direction | beat contents
//  req_    | in        | operation, sample_a/b/c
//  rsp_    | out       | grad_a/b/c, out_column, out_row, row_end, frame_end
//  csr_    | in        | write enable, index, data
// A pixel or drain beat moves the front sequencer from F_READ to F_EMIT, and on
// to F_LAST when it also yields the last result of a row; a pad ignored before
// the drain row is taken in F_READ. The line buffer read is registered.
// The back end is a 3-stage pipeline behind a 4-entry job queue.
// Synchronous reset clears counters, window and registers; line buffers are
// not cleared. Output stalls back up through the queue to req_stall.
`default_nettype none
module sobel_3x3_gradient_filter_core
   import sob_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int LANES     = LANES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_operation,
   input  wire logic [7:0]            req_sample_a,
   input  wire logic [7:0]            req_sample_b,
   input  wire logic [7:0]            req_sample_c,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [15:0]         rsp_grad_a,
   output logic signed [15:0]         rsp_grad_b,
   output logic signed [15:0]         rsp_grad_c,
   output logic [10:0]                rsp_out_column,
   output logic [11:0]                rsp_out_row,
   output logic                       rsp_row_end,
   output logic                       rsp_frame_end,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);
   logic [1:0] x_ff, y_ff, bm_ff, nch_ff;
   logic [23:0] bc_ff;
   logic [11:0] w_ff;
   logic [12:0] h_ff;
   logic [15:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= ORD_DERIV; y_ff <= ORD_SMOOTH; bm_ff <= BORDER_REPL; bc_ff <= '0;
         w_ff <= 12'd640; h_ff <= 13'd480; nch_ff <= 2'd1; gain_ff <= 16'd256;
      end else if (csr_write) begin
         case (csr_index)
            CSR_X_ORDER:  x_ff    <= csr_data[1:0];
            CSR_Y_ORDER:  y_ff    <= csr_data[1:0];
            CSR_BORDER:   bm_ff   <= csr_data[1:0];
            CSR_CONSTANT: bc_ff   <= csr_data[23:0];
            CSR_WIDTH:    w_ff    <= csr_data[11:0];
            CSR_HEIGHT:   h_ff    <= csr_data[12:0];
            CSR_CHANNELS: nch_ff  <= csr_data[1:0];
            CSR_GAIN:     gain_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic fj_valid, q_free, q_valid, q_take;
   job_type fj, qj;
   math_cfg_type mcfg;
   logic [2:0][15:0] grad;

   assign mcfg = '{x_order: x_ff, y_order: y_ff, nch: nch_ff, gain: gain_ff};

   sob_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall),
      .in_op(req_operation), .in_pix({req_sample_c, req_sample_b, req_sample_a}),
      .border_mode(bm_ff), .border_constant(bc_ff), .image_width(w_ff),
      .image_height(h_ff), .job_valid(fj_valid), .job(fj), .job_free(q_free));

   // the front registers its job, so the queue sees it in the cycle after job_go
   logic fj_d_ff;
   always_ff @(posedge clock) begin
      if (reset) fj_d_ff <= 1'b0;
      else       fj_d_ff <= fj_valid;
   end

   sob_queue u_queue (
      .clock, .reset, .wr_en(fj_d_ff), .wr_data(fj), .wr_free(q_free),
      .rd_valid(q_valid), .rd_data(qj), .rd_en(q_take));

   sob_back #(.LANES(LANES)) u_back (
      .clock, .reset, .job_valid(q_valid), .job(qj), .job_take(q_take), .cfg(mcfg),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_grad(grad),
      .out_column(rsp_out_column), .out_row(rsp_out_row),
      .out_row_end(rsp_row_end), .out_frame_end(rsp_frame_end));

   assign rsp_grad_a = grad[0];
   assign rsp_grad_b = grad[1];
   assign rsp_grad_c = grad[2];
endmodule
`default_nettype wire

### rtl/sob_front.sv
// Front end: line buffers, window, border handling and output tagging.
`default_nettype none
module sob_front
   import sob_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_stall,
   input  wire logic        in_op,
   input  wire logic [23:0] in_pix,
   input  wire logic [1:0]  border_mode,
   input  wire logic [23:0] border_constant,
   input  wire logic [11:0] image_width,
   input  wire logic [12:0] image_height,
   output logic             job_valid,
   output job_type          job,
   input  wire logic        job_free
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam logic [11:0] MAXW = 12'(MAX_WIDTH > 2048 ? 2048 : MAX_WIDTH);

   logic [23:0] upper_mem [MAX_WIDTH];
   logic [23:0] middle_mem [MAX_WIDTH];
   logic [23:0] up_ff, mid_ff;
   logic [8:0][23:0] win_ff, win_in;
   logic [10:0] col_ff, col_in;
   logic [12:0] row_ff, row_in;
   fstate_type st_ff, st_in;
   logic [11:0] w;
   logic [12:0] h, rr;
   logic [10:0] c;
   logic [1:0] mode;
   logic drain, take, have_first, have_last;
   logic [23:0] n, p, pix_ff;
   logic drain_ff, first_ff, last_ff;
   logic [10:0] c_ff;
   logic [12:0] rr_ff;
   job_type job_in;
   logic job_go;

   always_comb begin
      mode = (border_mode == 2'd3) ? BORDER_REPL : border_mode;
      w = (image_width < 12'd2) ? 12'd2 : (image_width > MAXW) ? MAXW : image_width;
      h = (image_height == 13'd0) ? 13'd1 : (image_height > 13'd4096) ? 13'd4096
                                                                        : image_height;
      rr = (row_ff > h) ? h : row_ff;
      drain = (rr == h);
      c = ({1'b0, col_ff} >= w) ? 11'(w - 12'd1) : col_ff;
      take = in_valid && (st_ff == F_READ);
   end

   assign in_stall = (st_ff != F_READ);

   // stage 1: read line buffers, latch item; upper line is refilled from the
   // registered middle read in the cycle after the read, in F_EMIT
   always_ff @(posedge clock) begin
      if (take && (!in_op || drain)) begin
         up_ff  <= upper_mem[AW'(c)];
         mid_ff <= middle_mem[AW'(c)];
         if (!drain)
            middle_mem[AW'(c)] <= in_pix;
         pix_ff   <= in_pix;
         drain_ff <= drain;
         c_ff     <= c;
         rr_ff    <= rr;
      end
      if (st_ff == F_EMIT && !drain_ff)
         upper_mem[AW'(c_ff)] <= mid_ff;
   end

   always_comb begin
      n = drain_ff ? ((mode == BORDER_CONST) ? border_constant :
                      (mode == BORDER_REFLECT && h >= 13'd2) ? up_ff : mid_ff) : pix_ff;
      p = (rr_ff >= 13'd2) ? up_ff : (mode == BORDER_CONST) ? border_constant :
          (mode == BORDER_REFLECT && h >= 13'd2) ? n : mid_ff;
      win_in = {n, mid_ff, p, win_ff[8:3]};
      have_first = (rr_ff >= 13'd1) && (c_ff >= 11'd1);
      have_last  = (rr_ff >= 13'd1) && ({1'b0, c_ff} == w - 12'd1);
      job_in = '0;
      job_in.row = 12'(rr_ff - 13'd1);
      for (int i = 0; i < 9; i++) job_in.cols[i] = win_ff[i];
      if (st_ff == F_EMIT) begin
         job_in.cols = win_in;
         job_in.column = c_ff - 11'd1;
         if (c_ff == 11'd1)
            for (int i = 0; i < 3; i++)
               job_in.cols[i] = (mode == BORDER_CONST) ? border_constant :
                                (mode == BORDER_REFLECT) ? win_in[6+i] : win_in[3+i];
      end else begin
         for (int i = 0; i < 6; i++) job_in.cols[i] = win_ff[3+i];
         for (int i = 0; i < 3; i++)
            job_in.cols[6+i] = (mode == BORDER_CONST) ? border_constant :
                               (mode == BORDER_REFLECT) ? win_ff[3+i] : win_ff[6+i];
         job_in.column = 11'(w - 12'd1);
         job_in.row_end = 1'b1;
         job_in.frame_end = (rr_ff == h);
      end
   end

   always_comb begin
      st_in = st_ff; col_in = col_ff; row_in = row_ff;
      job_go = 1'b0;
      case (st_ff)
         F_READ: if (take && (!in_op || drain)) begin
            st_in = F_EMIT;
            if ({1'b0, c} >= w - 12'd1) begin
               col_in = '0;
               row_in = drain ? 13'd0 : rr + 13'd1;
            end else begin
               col_in = c + 11'd1;
               row_in = rr;
            end
         end
         F_EMIT: if (!have_first || job_free) begin
            job_go = have_first;
            st_in = have_last ? F_LAST : F_READ;
         end
         F_LAST: if (job_free) begin
            job_go = 1'b1;
            st_in = F_READ;
         end
         default: st_in = F_READ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_READ; col_ff <= '0; row_ff <= '0; win_ff <= '0;
      end else begin
         st_ff <= st_in; col_ff <= col_in; row_ff <= row_in;
         if (st_ff == F_EMIT && st_in != F_EMIT) win_ff <= win_in;
      end
   end

   assign job_valid = job_go;
   always_ff @(posedge clock) if (job_go) job <= job_in;
endmodule
`default_nettype wire

### rtl/sob_queue.sv
// Short job queue between front and back ends.
`default_nettype none
module sob_queue
   import sob_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire job_type wr_data,
   output logic         wr_free,
   output logic         rd_valid,
   output job_type      rd_data,
   input  wire logic    rd_en
);
   job_type slot_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   // one slot in reserve covers the registered job in flight
   assign wr_free  = (cnt_ff < 3'd3);
   assign rd_valid = (cnt_ff != 3'd0);
   assign rd_data  = slot_ff[rp_ff];
   always_ff @(posedge clock) begin
      if (wr_en) slot_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 2'd1;
         if (rd_en) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(wr_en) - 3'(rd_en);
      end
   end
endmodule
`default_nettype wire

### rtl/sob_back.sv
// Back end: separable kernels, gain, rounding and output register.
`default_nettype none
module sob_back
   import sob_pkg::*;
#(
   parameter int LANES = LANES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         job_valid,
   input  wire job_type      job,
   output logic              job_take,
   input  wire math_cfg_type cfg,
   output logic              out_valid,
   input  wire logic         out_stall,
   output logic [2:0][15:0]  out_grad,
   output logic [10:0]       out_column,
   output logic [11:0]       out_row,
   output logic              out_row_end,
   output logic              out_frame_end
);
   // stage 1 sums, stage 2 products, stage 3 output
   logic s1_ff, s2_ff, o_ff;
   logic [2:0][15:0] sum_ff;
   logic signed [2:0][31:0] prod_ff;
   logic [10:0] c1_ff, c2_ff; logic [11:0] r1_ff, r2_ff;
   logic re1_ff, re2_ff, fe1_ff, fe2_ff;
   logic [2:0][15:0] sum_in, q_in;
   logic adv2, adv1, adv0;
   logic [1:0] nch;

   assign nch = (cfg.nch == 2'd0) ? 2'd1 :
                (cfg.nch > 2'(LANES)) ? 2'(LANES) : cfg.nch;
   assign adv2 = !o_ff || !out_stall;
   assign adv1 = !s2_ff || adv2;
   assign adv0 = !s1_ff || adv1;
   assign job_take = job_valid && adv0;

   always_comb begin
      logic [15:0] v0, v1, v2;
      logic [31:0] m;
      logic [16:0] mg;
      for (int ch = 0; ch < 3; ch++) begin
         v0 = tap3(cfg.y_order, {8'd0, job.cols[0][8*ch+:8]},
                   {8'd0, job.cols[1][8*ch+:8]}, {8'd0, job.cols[2][8*ch+:8]});
         v1 = tap3(cfg.y_order, {8'd0, job.cols[3][8*ch+:8]},
                   {8'd0, job.cols[4][8*ch+:8]}, {8'd0, job.cols[5][8*ch+:8]});
         v2 = tap3(cfg.y_order, {8'd0, job.cols[6][8*ch+:8]},
                   {8'd0, job.cols[7][8*ch+:8]}, {8'd0, job.cols[8][8*ch+:8]});
         sum_in[ch] = (2'(ch) < nch) ? tap3(cfg.x_order, v0, v1, v2) : 16'd0;
         m = prod_ff[ch][31] ? 32'(-prod_ff[ch]) : 32'(prod_ff[ch]);
         m = m + 32'd128;
         mg = (m[31:8] > 24'd65535) ? 17'h1FFFF : m[24:8];
         if (prod_ff[ch][31]) q_in[ch] = (mg > 17'd32768) ? 16'h8000 : 16'(-mg);
         else                 q_in[ch] = (mg > 17'd32767) ? 16'h7FFF : mg[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0; s2_ff <= 1'b0; o_ff <= 1'b0;
      end else begin
         if (adv0) s1_ff <= job_valid;
         if (adv1) s2_ff <= s1_ff;
         if (adv2) o_ff  <= s2_ff;
      end
      if (job_take) begin
         sum_ff <= sum_in; c1_ff <= job.column; r1_ff <= job.row;
         re1_ff <= job.row_end; fe1_ff <= job.frame_end;
      end
      if (adv1 && s1_ff) begin
         for (int ch = 0; ch < 3; ch++)
            prod_ff[ch] <= $signed(sum_ff[ch]) * $signed(cfg.gain);
         c2_ff <= c1_ff; r2_ff <= r1_ff; re2_ff <= re1_ff; fe2_ff <= fe1_ff;
      end
      if (adv2 && s2_ff) begin
         out_grad <= q_in; out_column <= c2_ff; out_row <= r2_ff;
         out_row_end <= re2_ff; out_frame_end <= fe2_ff;
      end
   end
   assign out_valid = o_ff;
endmodule
`default_nettype wire
